@@ hdl/gn2_pkg.sv @@
// gn2_pkg: shared types and constants for the 2d gradient noise unit
// no dependencies
`timescale 1ns / 1ps

package gn2_pkg;

   localparam int CoordWidth = 24;
   localparam int FracBits   = 16;
   localparam int IntBits    = CoordWidth - FracBits;
   localparam int AddrWidth  = 8;
   localparam int TableDepth = 1 << AddrWidth;
   localparam int ByteWidth  = 8;
   localparam int NoiseWidth = 19;

   localparam int One        = 1 << FracBits;
   localparam int Half       = 1 << (FracBits - 1);

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_EVAL  = 1'b1
   } cmd_type;

   // classified item passed from the front end to the evaluation pipeline
   typedef struct packed {
      logic                 is_eval;
      logic [AddrWidth-1:0] addr;
      logic [ByteWidth-1:0] wdata;
      logic [AddrWidth-1:0] ix;
      logic [AddrWidth-1:0] iy;
      logic [FracBits-1:0]  tx;
      logic [FracBits-1:0]  ty;
   } op_type;

endpackage

@@ hdl/gn2_ifs.sv @@
// gn2_req_if / gn2_rsp_if: valid-ready channels of the noise unit
// depends on gn2_pkg
`timescale 1ns / 1ps

interface gn2_req_if;
   import gn2_pkg::*;
   logic                  valid;
   logic                  ready;
   cmd_type               command;
   logic [AddrWidth-1:0]  table_index;
   logic [ByteWidth-1:0]  table_value;
   logic [CoordWidth-1:0] coord_x;
   logic [CoordWidth-1:0] coord_y;
   modport source (output valid, command, table_index, table_value, coord_x, coord_y,
                   input ready);
   modport sink   (input valid, command, table_index, table_value, coord_x, coord_y,
                   output ready);
endinterface

interface gn2_rsp_if;
   import gn2_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [NoiseWidth-1:0] noise_value;
   modport source (output valid, noise_value, input ready);
   modport sink   (input valid, noise_value, output ready);
endinterface

@@ hdl/gn2_hash_ram.sv @@
// gn2_hash_ram: one copy of the hash table, one write port, two registered read ports
// depends on gn2_pkg
`timescale 1ns / 1ps

module gn2_hash_ram (
   input  logic                          clock,
   input  logic                          we,
   input  logic [gn2_pkg::AddrWidth-1:0] waddr,
   input  logic [gn2_pkg::ByteWidth-1:0] wdata,
   input  logic [gn2_pkg::AddrWidth-1:0] raddr0,
   input  logic [gn2_pkg::AddrWidth-1:0] raddr1,
   output logic [gn2_pkg::ByteWidth-1:0] q0,
   output logic [gn2_pkg::ByteWidth-1:0] q1
);
   import gn2_pkg::*;

   logic [ByteWidth-1:0] mem [TableDepth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      q0 <= mem[raddr0];
      q1 <= mem[raddr1];
   end

endmodule

@@ hdl/gn2_front.sv @@
// gn2_front: accepts request beats and splits them into table writes and evaluations
// depends on gn2_pkg, gn2_req_if
`timescale 1ns / 1ps

module gn2_front (
   input  logic            clock,
   input  logic            reset,
   gn2_req_if.sink         req,
   output logic            q_valid,
   input  logic            q_ready,
   output gn2_pkg::op_type q_op
);
   import gn2_pkg::*;

   logic   vld_ff;
   logic   vld_in;
   op_type op_ff;
   op_type op_in;

   assign req.ready = !vld_ff || q_ready;
   assign vld_in    = req.ready ? req.valid : vld_ff;

   always_comb begin
      op_in.is_eval = (req.command == CMD_EVAL);
      op_in.addr    = req.table_index;
      op_in.wdata   = req.table_value;
      op_in.ix      = req.coord_x[CoordWidth-1 -: IntBits];
      op_in.iy      = req.coord_y[CoordWidth-1 -: IntBits];
      op_in.tx      = req.coord_x[FracBits-1:0];
      op_in.ty      = req.coord_y[FracBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         op_ff <= op_in;
      end
   end

   assign q_valid = vld_ff;
   assign q_op    = op_ff;

endmodule

@@ hdl/gn2_queue.sv @@
// gn2_queue: four-entry queue of classified items between front and back
// depends on gn2_pkg
`timescale 1ns / 1ps

module gn2_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  gn2_pkg::op_type in_op,
   output logic            out_valid,
   input  logic            out_ready,
   output gn2_pkg::op_type out_op
);
   import gn2_pkg::*;

   localparam int Depth = 4;
   localparam int PtrW  = 2;

   op_type          slot_ff [Depth];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]   cnt_ff, cnt_in;
   logic            push, pop;

   assign in_ready  = (cnt_ff != (PtrW+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign out_op    = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? wr_ff + PtrW'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PtrW'(1) : rd_ff;
      cnt_in = cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= in_op;
      end
   end

endmodule

@@ hdl/gn2_back.sv @@
// gn2_back: hash lookups, fade curves, gradient blend and result buffer
// depends on gn2_pkg, gn2_rsp_if, gn2_hash_ram
`timescale 1ns / 1ps

module gn2_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            op_valid,
   output logic            op_ready,
   input  gn2_pkg::op_type op,
   gn2_rsp_if.source       rsp
);
   import gn2_pkg::*;

   localparam int OutDepth = 16;
   localparam int OutAw    = 4;
   localparam int Lat      = 10;
   localparam int CWidth   = FracBits + 4;
   localparam int PuWidth  = FracBits + CWidth;
   localparam int GWidth   = FracBits + 3;
   localparam int DWidth   = FracBits + 4;
   localparam int MWidth   = DWidth - 1;
   localparam int P0Width  = FracBits + 1 + MWidth;
   localparam int P1Width  = FracBits + 1 + DWidth;
   localparam int RWidth   = DWidth + 3;
   localparam int TenOne   = 10 * One;
   localparam int NoiseMax = (1 << (NoiseWidth - 1)) - 1;
   localparam int NoiseMin = -(1 << (NoiseWidth - 1));

   function automatic logic signed [GWidth-1:0] corner_val(
      input logic [ByteWidth-1:0]       h,
      input logic signed [FracBits+1:0] dx,
      input logic signed [FracBits+1:0] dy
   );
      logic signed [GWidth-1:0] gx;
      logic signed [GWidth-1:0] gy;
      gx = h[0] ? GWidth'(dx) : -GWidth'(dx);
      gy = h[1] ? GWidth'(dy) : -GWidth'(dy);
      return gx + gy;
   endfunction

   // issue control and credits for the result buffer
   logic            issue, issue_eval, rsp_pop, push;
   logic [OutAw:0]  credit_ff, credit_in;
   logic [2:1]      vld_ff;
   logic [Lat:1]    ev_ff;
   op_type          op1_ff, op2_ff, op3_ff;

   assign op_ready   = !op.is_eval || (credit_ff < (OutAw+1)'(OutDepth));
   assign issue      = op_valid && op_ready;
   assign issue_eval = issue && op.is_eval;
   assign rsp_pop    = rsp.valid && rsp.ready;
   assign push       = ev_ff[Lat];
   assign credit_in  = credit_ff + (OutAw+1)'(issue_eval) - (OutAw+1)'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         vld_ff    <= '0;
         ev_ff     <= '0;
      end else begin
         credit_ff <= credit_in;
         vld_ff    <= {vld_ff[1], issue};
         ev_ff     <= {ev_ff[Lat-1:1], issue_eval};
      end
   end

   always_ff @(posedge clock) begin
      op1_ff <= op;
      op2_ff <= op1_ff;
      op3_ff <= op2_ff;
   end

   // chained hash lookups: table copy a in the first stage, b and c in the next, then d and e
   logic [ByteWidth-1:0] qa0, qa1, qb0, qb1, qc0, qc1, qd0, qd1, qe0, qe1;
   logic [AddrWidth-1:0] hash_a, hash_b;

   assign hash_a = qa0 + op1_ff.iy;
   assign hash_b = qa1 + op1_ff.iy;

   gn2_hash_ram u_ram_a (
      .clock (clock), .we (issue && !op.is_eval), .waddr (op.addr), .wdata (op.wdata),
      .raddr0 (op.ix), .raddr1 (op.ix + AddrWidth'(1)), .q0 (qa0), .q1 (qa1)
   );
   gn2_hash_ram u_ram_b (
      .clock (clock), .we (vld_ff[1] && !op1_ff.is_eval), .waddr (op1_ff.addr),
      .wdata (op1_ff.wdata), .raddr0 (hash_a), .raddr1 (hash_a + AddrWidth'(1)),
      .q0 (qb0), .q1 (qb1)
   );
   gn2_hash_ram u_ram_c (
      .clock (clock), .we (vld_ff[1] && !op1_ff.is_eval), .waddr (op1_ff.addr),
      .wdata (op1_ff.wdata), .raddr0 (hash_b), .raddr1 (hash_b + AddrWidth'(1)),
      .q0 (qc0), .q1 (qc1)
   );
   gn2_hash_ram u_ram_d (
      .clock (clock), .we (vld_ff[2] && !op2_ff.is_eval), .waddr (op2_ff.addr),
      .wdata (op2_ff.wdata), .raddr0 (qb0), .raddr1 (qc0), .q0 (qd0), .q1 (qd1)
   );
   gn2_hash_ram u_ram_e (
      .clock (clock), .we (vld_ff[2] && !op2_ff.is_eval), .waddr (op2_ff.addr),
      .wdata (op2_ff.wdata), .raddr0 (qb1), .raddr1 (qc1), .q0 (qe0), .q1 (qe1)
   );

   // fade curve lanes: lane 0 for x, lane 1 for y
   logic [FracBits-1:0]   t_lane [2];
   logic [FracBits-1:0]   t0_ff [2], t1_ff [2], t2_ff [2], t3_ff [2];
   logic [FracBits-1:0]   t2_in [2], t3_in [2];
   logic [2*FracBits-1:0] tt_ff [2], p3_ff [2];
   logic [2*FracBits:0]   tt_sum [2], p3_sum [2];
   logic [CWidth:0]       c_full [2];
   logic [CWidth-1:0]     c_ff [2], c2_ff [2];
   logic [PuWidth-1:0]    pu_ff [2];
   logic [PuWidth:0]      pu_sum [2];
   logic [PuWidth-FracBits:0] pu_rnd [2];
   logic [FracBits:0]     u_ff [2], u_in [2];
   logic [FracBits:0]     v7_ff, v8_ff, v9_ff;

   assign t_lane[0] = op.tx;
   assign t_lane[1] = op.ty;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         tt_sum[l] = {1'b0, tt_ff[l]} + (2*FracBits+1)'(Half);
         t2_in[l]  = tt_sum[l][2*FracBits-1:FracBits];
         c_full[l] = (CWidth+1)'(6) * (CWidth+1)'(t2_ff[l]) + (CWidth+1)'(TenOne)
                   - (CWidth+1)'(15) * (CWidth+1)'(t1_ff[l]);
         p3_sum[l] = {1'b0, p3_ff[l]} + (2*FracBits+1)'(Half);
         t3_in[l]  = p3_sum[l][2*FracBits-1:FracBits];
         pu_sum[l] = {1'b0, pu_ff[l]} + (PuWidth+1)'(Half);
         pu_rnd[l] = pu_sum[l][PuWidth:FracBits];
         u_in[l]   = (pu_rnd[l] > (PuWidth-FracBits+1)'(One)) ? (FracBits+1)'(One)
                                                              : pu_rnd[l][FracBits:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         t0_ff[l] <= t_lane[l];
         tt_ff[l] <= (2*FracBits)'(t_lane[l]) * (2*FracBits)'(t_lane[l]);
         t2_ff[l] <= t2_in[l];
         t1_ff[l] <= t0_ff[l];
         p3_ff[l] <= (2*FracBits)'(t2_ff[l]) * (2*FracBits)'(t1_ff[l]);
         c_ff[l]  <= c_full[l][CWidth-1:0];
         t3_ff[l] <= t3_in[l];
         c2_ff[l] <= c_ff[l];
         pu_ff[l] <= PuWidth'(t3_ff[l]) * PuWidth'(c2_ff[l]);
         u_ff[l]  <= u_in[l];
      end
      v7_ff <= u_ff[1];
      v8_ff <= v7_ff;
      v9_ff <= v8_ff;
   end

   // corner gradients, the two blends along x, the blend along y and saturation
   logic signed [FracBits+1:0] fx, fy, fx1, fy1;
   logic signed [GWidth-1:0]   g00_ff, g10_ff, g01_ff, g11_ff;
   logic signed [GWidth-1:0]   a0_ff, a1_ff, a0b_ff, a1b_ff, a0c_ff, a1c_ff;
   logic signed [DWidth-1:0]   d0_ff, d1_ff;
   logic [MWidth-1:0]          m0_ff, m1_ff;
   logic                       n0_ff, n1_ff, n0c_ff, n1c_ff;
   logic [P0Width-1:0]         pr0_ff, pr1_ff;
   logic [P0Width:0]           pr0_sum, pr1_sum;
   logic signed [DWidth:0]     l0_full, l1_full;
   logic signed [DWidth-1:0]   l0_ff, l1_ff, la_ff, lb_ff;
   logic signed [DWidth:0]     dl;
   logic [DWidth-1:0]          ml_ff;
   logic                       nl_ff, nb_ff;
   logic [P1Width-1:0]         pr_ff;
   logic [P1Width:0]           pr_sum;
   logic signed [RWidth-1:0]   r_full;
   logic signed [NoiseWidth-1:0] r_sat;

   assign fx  = $signed({2'b00, op3_ff.tx});
   assign fy  = $signed({2'b00, op3_ff.ty});
   assign fx1 = fx - $signed((FracBits+2)'(One));
   assign fy1 = fy - $signed((FracBits+2)'(One));

   always_comb begin
      pr0_sum = {1'b0, pr0_ff} + (P0Width+1)'(Half);
      pr1_sum = {1'b0, pr1_ff} + (P0Width+1)'(Half);
      l0_full = n0c_ff ? (DWidth+1)'(a0c_ff) - $signed({1'b0, pr0_sum[P0Width-1:FracBits]})
                       : (DWidth+1)'(a0c_ff) + $signed({1'b0, pr0_sum[P0Width-1:FracBits]});
      l1_full = n1c_ff ? (DWidth+1)'(a1c_ff) - $signed({1'b0, pr1_sum[P0Width-1:FracBits]})
                       : (DWidth+1)'(a1c_ff) + $signed({1'b0, pr1_sum[P0Width-1:FracBits]});
      dl      = (DWidth+1)'(l1_ff) - (DWidth+1)'(l0_ff);
      pr_sum  = {1'b0, pr_ff} + (P1Width+1)'(Half);
      r_full  = nb_ff ? RWidth'(lb_ff) - $signed({1'b0, pr_sum[P1Width-1:FracBits]})
                      : RWidth'(lb_ff) + $signed({1'b0, pr_sum[P1Width-1:FracBits]});
      if (r_full > RWidth'(NoiseMax)) begin
         r_sat = NoiseWidth'(NoiseMax);
      end else if (r_full < RWidth'(NoiseMin)) begin
         r_sat = NoiseWidth'(NoiseMin);
      end else begin
         r_sat = r_full[NoiseWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      g00_ff <= corner_val(qd0, fx, fy);
      g10_ff <= corner_val(qd1, fx1, fy);
      g01_ff <= corner_val(qe0, fx, fy1);
      g11_ff <= corner_val(qe1, fx1, fy1);
      a0_ff  <= g00_ff;
      a1_ff  <= g01_ff;
      d0_ff  <= DWidth'(g10_ff) - DWidth'(g00_ff);
      d1_ff  <= DWidth'(g11_ff) - DWidth'(g01_ff);
      a0b_ff <= a0_ff;
      a1b_ff <= a1_ff;
      m0_ff  <= d0_ff[DWidth-1] ? MWidth'(-d0_ff) : MWidth'(d0_ff);
      m1_ff  <= d1_ff[DWidth-1] ? MWidth'(-d1_ff) : MWidth'(d1_ff);
      n0_ff  <= d0_ff[DWidth-1];
      n1_ff  <= d1_ff[DWidth-1];
      pr0_ff <= P0Width'(u_ff[0]) * P0Width'(m0_ff);
      pr1_ff <= P0Width'(u_ff[0]) * P0Width'(m1_ff);
      a0c_ff <= a0b_ff;
      a1c_ff <= a1b_ff;
      n0c_ff <= n0_ff;
      n1c_ff <= n1_ff;
      l0_ff  <= l0_full[DWidth-1:0];
      l1_ff  <= l1_full[DWidth-1:0];
      la_ff  <= l0_ff;
      ml_ff  <= dl[DWidth] ? DWidth'(-dl) : DWidth'(dl);
      nl_ff  <= dl[DWidth];
      pr_ff  <= P1Width'(v9_ff) * P1Width'(ml_ff);
      lb_ff  <= la_ff;
      nb_ff  <= nl_ff;
   end

   // result buffer
   logic signed [NoiseWidth-1:0] out_ff [OutDepth];
   logic [OutAw-1:0]             wr_ff, wr_in, rd_ff, rd_in;
   logic [OutAw:0]               cnt_ff, cnt_in;

   assign wr_in  = push ? wr_ff + OutAw'(1) : wr_ff;
   assign rd_in  = rsp_pop ? rd_ff + OutAw'(1) : rd_ff;
   assign cnt_in = cnt_ff + (OutAw+1)'(push) - (OutAw+1)'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_ff[wr_ff] <= r_sat;
      end
   end

   assign rsp.valid       = (cnt_ff != '0);
   assign rsp.noise_value = out_ff[rd_ff];

endmodule

@@ hdl/gradient_noise_2d_unit.sv @@
// gradient_noise_2d_unit: top level of the 2d gradient noise unit
// depends on gn2_pkg, gn2_ifs, gn2_front, gn2_queue, gn2_back
//
//   channel   dir   beat contents
//   req_if    in    command, table_index, table_value, coord_x, coord_y
//   rsp_if    out   noise_value (signed q2.16), one per evaluate command
//
// one beat per cycle sustained, writes and evaluations alike, unless a full result buffer stalls
// an evaluation reaches the result buffer through the chained table lookups, the
//   fade multiplies and the two blend stages
// the hash table is replicated across the lookup stages (copies a to e in gn2_back);
//   each copy takes a write as it passes its stage, so ordering against evaluations is kept
// result buffer holds 16 beats; rsp stalls back up through a 4-entry queue
// synchronous reset clears control state only; the hash table is not cleared
`timescale 1ns / 1ps

module gradient_noise_2d_unit (
   input  logic      clock,
   input  logic      reset,
   gn2_req_if.sink   req_if,
   gn2_rsp_if.source rsp_if
);
   import gn2_pkg::*;

   logic   fq_valid, fq_ready, qb_valid, qb_ready;
   op_type fq_op, qb_op;

   gn2_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .q_valid (fq_valid),
      .q_ready (fq_ready),
      .q_op    (fq_op)
   );

   gn2_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_op     (fq_op),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_op    (qb_op)
   );

   gn2_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (qb_valid),
      .op_ready (qb_ready),
      .op       (qb_op),
      .rsp      (rsp_if)
   );

endmodule

@@ hdl/gn2_checker.sv @@
// gn2_checker: port-level checks for gradient_noise_2d_unit, bound to the top level
// depends on gn2_pkg
`timescale 1ns / 1ps

module gn2_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input gn2_pkg::cmd_type                     req_command,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [gn2_pkg::NoiseWidth-1:0] rsp_noise_value
);
   import gn2_pkg::*;

   localparam int NoiseLim = 2 * One;

   // evaluations accepted and not yet answered
   logic [7:0] pend_ff, pend_in;

   assign pend_in = pend_ff + 8'(req_valid && req_ready && req_command == CMD_EVAL)
                  - 8'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_noise_value))
      else $error("rsp beat dropped or changed while stalled");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != '0)
      else $error("rsp beat without a pending evaluation");

   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid straight after reset");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_noise_value <= NoiseWidth'(NoiseLim))
                 && (rsp_noise_value >= -NoiseWidth'(NoiseLim)))
      else $error("noise value out of range");

endmodule

bind gradient_noise_2d_unit gn2_checker u_gn2_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .req_command     (req_if.command),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_noise_value (rsp_if.noise_value)
);

@@ tb/sv/gn2_noise_checker.sv @@
// gn2_noise_checker: watches the request and result channels of the noise unit,
// predicts each noise value from its own copy of the hash table and compares
// depends on gn2_pkg, gn2_ifs
`timescale 1ns / 1ps

module gn2_noise_checker (
   input  logic clock,
   input  logic reset,
   gn2_req_if   req_if,
   gn2_rsp_if   rsp_if,
   output int   fail_count,
   output int   pending
);
   import gn2_pkg::*;

   logic [ByteWidth-1:0]         hash_copy [TableDepth];
   logic signed [NoiseWidth-1:0] noise_queue [$];

   function automatic longint fx_round(longint p);
      return (p + Half) >>> FracBits;
   endfunction

   function automatic longint fade_curve(longint t);
      longint t2, t3, c, u;
      t2 = fx_round(t * t);
      t3 = fx_round(t2 * t);
      c  = 6 * t2 + 10 * One - 15 * t;
      u  = fx_round(t3 * c);
      return (u > One) ? One : u;
   endfunction

   function automatic longint blend(longint u, longint a, longint b);
      longint d, p;
      d = b - a;
      p = fx_round(u * ((d < 0) ? -d : d));
      return (d < 0) ? a - p : a + p;
   endfunction

   function automatic longint grad_dot(logic [ByteWidth-1:0] h, longint dx, longint dy);
      return (h[0] ? dx : -dx) + (h[1] ? dy : -dy);
   endfunction

   function automatic logic [ByteWidth-1:0] hash_at(longint idx);
      return hash_copy[idx % TableDepth];
   endfunction

   function automatic logic signed [NoiseWidth-1:0] noise_at(
         logic [CoordWidth-1:0] cx, logic [CoordWidth-1:0] cy);
      longint ix, iy, tx, ty, u, v, a, b, aa, ab, ba, bb, l0, l1, r;
      ix = (cx >> FracBits) % TableDepth;
      iy = (cy >> FracBits) % TableDepth;
      tx = cx[FracBits-1:0];
      ty = cy[FracBits-1:0];
      u  = fade_curve(tx);
      v  = fade_curve(ty);
      a  = hash_at(ix) + iy;
      aa = hash_at(a);
      ab = hash_at(a + 1);
      b  = hash_at(ix + 1) + iy;
      ba = hash_at(b);
      bb = hash_at(b + 1);
      l0 = blend(u, grad_dot(hash_at(aa), tx, ty), grad_dot(hash_at(ba), tx - One, ty));
      l1 = blend(u, grad_dot(hash_at(ab), tx, ty - One),
                 grad_dot(hash_at(bb), tx - One, ty - One));
      r  = blend(v, l0, l1);
      if (r > 262143) r = 262143;
      if (r < -262144) r = -262144;
      return r[NoiseWidth-1:0];
   endfunction

   initial fail_count = 0;
   initial pending = 0;

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         if (req_if.command == CMD_WRITE)
            hash_copy[req_if.table_index] = req_if.table_value;
         else
            noise_queue.push_back(noise_at(req_if.coord_x, req_if.coord_y));
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (noise_queue.size() == 0) begin
            $error("unexpected result beat: noise_value %0d", rsp_if.noise_value);
            fail_count++;
         end else if (rsp_if.noise_value !== noise_queue[0]) begin
            $error("noise_value mismatch: expected %0d actual %0d",
                   noise_queue[0], rsp_if.noise_value);
            fail_count++;
            void'(noise_queue.pop_front());
         end else begin
            void'(noise_queue.pop_front());
         end
      end
      pending = noise_queue.size();
   end

endmodule

@@ tb/sv/tb_top.sv @@
// tb_top: stimulus and verdict for gradient_noise_2d_unit
// depends on gn2_pkg, gn2_ifs, gn2_noise_checker and the unit itself
`timescale 1ns / 1ps

module tb_top;
   import gn2_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   cycles;
   int   max_gap;
   int   max_stall;

   gn2_req_if req_bus();
   gn2_rsp_if rsp_bus();

   gradient_noise_2d_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   gn2_noise_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_bus),
      .rsp_if     (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      req_bus.valid       <= 1'b0;
      req_bus.command     <= CMD_WRITE;
      req_bus.table_index <= '0;
      req_bus.table_value <= '0;
      req_bus.coord_x     <= '0;
      req_bus.coord_y     <= '0;
      rsp_bus.ready       <= 1'b0;
   end

   // timeout
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 500000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side stalls
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, max_stall);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   task automatic send_beat(cmd_type cmd, logic [AddrWidth-1:0] idx,
                            logic [ByteWidth-1:0] val,
                            logic [CoordWidth-1:0] cx, logic [CoordWidth-1:0] cy);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.command     <= cmd;
      req_bus.table_index <= idx;
      req_bus.table_value <= val;
      req_bus.coord_x     <= cx;
      req_bus.coord_y     <= cy;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic eval_at(logic [CoordWidth-1:0] cx, logic [CoordWidth-1:0] cy);
      send_beat(CMD_EVAL, AddrWidth'($urandom), ByteWidth'($urandom), cx, cy);
   endtask

   task automatic drain;
      req_bus.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [CoordWidth-1:0] rand_coord();
      logic [CoordWidth-1:0] c;
      c = CoordWidth'($urandom);
      case ($urandom_range(0, 7))
         0: c[FracBits-1:0] = '0;
         1: c[FracBits-1:0] = '1;
         2: c[FracBits-1:0] = FracBits'(Half);
         3: c[CoordWidth-1:FracBits] = '1;
         default: ;
      endcase
      return c;
   endfunction

   initial begin
      reset     <= 1'b1;
      max_gap   = 0;
      max_stall = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // every entry written before any lookup
      for (int i = 0; i < TableDepth; i++)
         send_beat(CMD_WRITE, AddrWidth'(i), ByteWidth'($urandom),
                   CoordWidth'($urandom), CoordWidth'($urandom));

      // directed corners of the coordinate space
      max_gap   = 3;
      max_stall = 3;
      send_beat(CMD_WRITE, '0, 8'hff, '0, '0);
      send_beat(CMD_WRITE, 8'hff, 8'h00, '1, '1);
      eval_at('0, '0);
      eval_at('1, '1);
      eval_at('1, '0);
      eval_at('0, '1);
      eval_at(24'h00_8000, 24'h00_8000);
      eval_at(24'h00_ffff, 24'h00_0001);
      eval_at(24'hff_0000, 24'hff_0000);
      eval_at(24'hff_8000, 24'h01_ffff);
      eval_at(24'h7f_4000, 24'h80_c000);
      eval_at(24'h01_0000, 24'hfe_ffff);
      eval_at(24'haa_5555, 24'h55_aaaa);
      eval_at(24'h55_aaaa, 24'haa_5555);
      drain();

      // random phases, cycling through busy, idle-heavy and stall-heavy traffic
      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 3)
            0: begin max_gap = 0;  max_stall = 0;  end
            1: begin max_gap = 12; max_stall = 12; end
            default: begin max_gap = 2; max_stall = 12; end
         endcase
         for (int n = 0; n < 240; n++) begin
            if ($urandom_range(0, 9) < 2)
               send_beat(CMD_WRITE, AddrWidth'($urandom), ByteWidth'($urandom),
                         CoordWidth'($urandom), CoordWidth'($urandom));
            else
               eval_at(rand_coord(), rand_coord());
         end
         drain();
      end

      drain();
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/gn2_pkg.sv
hdl/gn2_ifs.sv
hdl/gn2_hash_ram.sv
hdl/gn2_front.sv
hdl/gn2_queue.sv
hdl/gn2_back.sv
hdl/gradient_noise_2d_unit.sv
hdl/gn2_checker.sv
tb/sv/gn2_noise_checker.sv
tb/sv/tb_top.sv
